// ===== hdl/tdi_pkg.sv =====
// types, constants, threshold tables and control store for the thermal derating block
package tdi_pkg;

	localparam int LEVELS  = 7;
	localparam int LVL_W   = 3;
	localparam int TEMP_W  = 16;
	localparam int ADJ_W   = 13;
	localparam int CA_W    = 16;
	localparam int THR_W   = 18;
	localparam int SPAN_W  = 16;
	localparam int DIST_W  = 17;
	localparam int GAIN_W  = 15;
	localparam int PROD_W  = 32;
	localparam int CNT_W   = 5;
	localparam int STEP_W  = 3;
	localparam int STEPS   = 8;
	localparam int TOP_PCT = 100;

	localparam logic [CA_W-1:0] CA_RESET = 16'd6400;

	typedef struct packed {
		logic signed [TEMP_W-1:0] led_temp;
		logic signed [TEMP_W-1:0] mcu_temp;
	} item_t;

	typedef struct packed {
		logic [ADJ_W-1:0] temp_adjust;
		logic [LVL_W-1:0] protect_level;
		logic             derate_source;
		logic             temp_error;
	} result_t;

	typedef logic signed [THR_W-1:0] thr_t;
	typedef thr_t thr_tab_t [LEVELS];

	// base temperatures in whole degrees
	localparam int LED_BASE [LEVELS] = '{-40, 110, 114, 118, 122, 125, 129};
	localparam int MCU_BASE [LEVELS] = '{-40, 114, 118, 122, 126, 130, 135};

	// intensity in percent per level, last entry pads the final segment
	localparam logic [6:0] INTENSITY [LEVELS+1] =
		'{7'd100, 7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd0, 7'd0};

	function automatic thr_tab_t thr_table(input logic is_mcu, input int scale);
		thr_tab_t tab;
		for (int k = 0; k < LEVELS; k++) begin
			tab[k] = is_mcu ? THR_W'(MCU_BASE[k] * scale) : THR_W'(LED_BASE[k] * scale);
		end
		return tab;
	endfunction

	// step addresses
	typedef logic [STEP_W-1:0] step_t;
	localparam step_t ST_IDLE   = 3'd0;
	localparam step_t ST_LEVEL  = 3'd1;
	localparam step_t ST_SEG    = 3'd2;
	localparam step_t ST_MUL    = 3'd3;
	localparam step_t ST_DIV    = 3'd4;
	localparam step_t ST_TARGET = 3'd5;
	localparam step_t ST_SLEW   = 3'd6;
	localparam step_t ST_EMIT   = 3'd7;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LEVEL,
		OP_SEG,
		OP_MUL,
		OP_DIV,
		OP_TARGET,
		OP_SLEW,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		C_ALWAYS,
		C_IN_VALID,
		C_FLAT,
		C_DIV_BUSY,
		C_OUT_FREE
	} cond_t;

	// one control word: operation, branch condition, taken and not-taken targets, input-take flag
	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t jt;
		step_t jf;
		logic  take_in;
	} ucode_t;

	localparam ucode_t UCODE [STEPS] = '{
		'{OP_NONE,   C_IN_VALID, ST_LEVEL,  ST_IDLE,   1'b1},
		'{OP_LEVEL,  C_ALWAYS,   ST_SEG,    ST_SEG,    1'b0},
		'{OP_SEG,    C_FLAT,     ST_TARGET, ST_MUL,    1'b0},
		'{OP_MUL,    C_ALWAYS,   ST_DIV,    ST_DIV,    1'b0},
		'{OP_DIV,    C_DIV_BUSY, ST_DIV,    ST_TARGET, 1'b0},
		'{OP_TARGET, C_ALWAYS,   ST_SLEW,   ST_SLEW,   1'b0},
		'{OP_SLEW,   C_ALWAYS,   ST_EMIT,   ST_EMIT,   1'b0},
		'{OP_EMIT,   C_OUT_FREE, ST_IDLE,   ST_EMIT,   1'b0}
	};

endpackage

// ===== hdl/thermal_derating_intensity.sv =====
// thermal derating of the intensity factor, microcoded sequencer over a small datapath
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+-------------------------------------------
//  item     | item_valid / item_ready     | led_temp, mcu_temp (signed 16 bit)
//  result   | result_valid / result_ready | temp_adjust, protect_level, derate_source,
//           |                             | temp_error
//
//  when the governing level lies on a sloped segment (levels 1 to 5), an item runs through
//  the 32 steps of the one-bit-per-cycle restoring divider before the next item slot is
//  free; flat segments (levels 0 and 6) skip the multiply and divide
//  reset clears both levels, loads 6400 into the slewed output and empties the result
//  register; there is no clearing pass
//  the result sits in an output register, so the sequencer only stalls in its last step
//  when that register still holds an untaken result
module thermal_derating_intensity #(
	parameter int TEMP_SCALE      = 10,
	parameter int INTENSITY_SHIFT = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  tdi_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output tdi_pkg::result_t result
);
	import tdi_pkg::*;

	// scaled thresholds, worked out at elaboration
	localparam thr_tab_t LED_THR = thr_table(1'b0, TEMP_SCALE);
	localparam thr_tab_t MCU_THR = thr_table(1'b1, TEMP_SCALE);
	localparam thr_t     SCALE_T = THR_W'(TEMP_SCALE);
	// full-intensity value and the largest value the slewed output can hold
	localparam logic [CA_W-1:0] TOP    = CA_W'(TOP_PCT << INTENSITY_SHIFT);
	localparam logic [CA_W-1:0] CA_MAX = (TOP > CA_RESET) ? TOP : CA_RESET;
	localparam int              SLEW_SH = INTENSITY_SHIFT + 1;

	// level search with hysteresis: first open band wins, outside every band the old level holds
	function automatic logic [LVL_W-1:0] level_of(input thr_t t, input thr_tab_t tab,
			input logic [LVL_W-1:0] old);
		logic [LVL_W-1:0] lvl;
		logic             found;
		logic             above5;
		thr_t             lo;
		thr_t             hi;
		lvl    = old;
		found  = 1'b0;
		above5 = (t >= tab[LEVELS-2]);
		if (t <= tab[0]) begin
			lvl = old;
		end else if (t >= tab[LEVELS-1]) begin
			lvl = LVL_W'(LEVELS - 1);
		end else begin
			for (int k = 0; k < LEVELS - 1; k++) begin
				lo = tab[k] + SCALE_T;
				hi = tab[k+1] - (above5 ? (SCALE_T <<< 1) : SCALE_T);
				if (!found && t >= lo && t < hi) begin
					lvl   = LVL_W'(k);
					found = 1'b1;
				end
			end
		end
		return lvl;
	endfunction

	// sequencer
	step_t  pc_q;
	ucode_t cw;
	logic   cond_true;
	logic   out_free;

	// datapath registers
	item_t               item_q;
	logic [LVL_W-1:0]    led_level_q;
	logic [LVL_W-1:0]    mcu_level_q;
	logic [LVL_W-1:0]    lvl_q;
	logic                src_q;
	logic                err_q;
	thr_t                tsel_q;
	logic                flat_q;
	logic                ge_q;
	logic [GAIN_W-1:0]   cur_q;
	logic [GAIN_W-1:0]   gain_q;
	logic [DIST_W-1:0]   dist_q;
	logic [SPAN_W-1:0]   span_q;
	logic [PROD_W-1:0]   quo_q;
	logic [SPAN_W-1:0]   rem_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CA_W-1:0]     target_q;
	logic [CA_W-1:0]     ca_q;
	result_t             out_q;
	logic                out_valid_q;

	// level step
	thr_t             lt_c;
	thr_t             mt_c;
	logic [LVL_W-1:0] nl_c;
	logic [LVL_W-1:0] nm_c;
	logic             mcu_rules_c;

	// segment step
	logic [LVL_W-1:0]  nxt_idx_c;
	thr_t              tl_c;
	thr_t              th_c;
	thr_t              dist_c;
	thr_t              span_c;
	logic [GAIN_W-1:0] cur_c;
	logic [GAIN_W-1:0] nxt_c;
	logic              flat_c;
	logic              ge_c;

	// divide step
	logic [SPAN_W:0]   r2_c;
	logic [SPAN_W:0]   rsub_c;
	logic              qbit_c;

	// target and slew steps
	logic [PROD_W-1:0] cur_w_c;
	logic [PROD_W:0]   up_c;
	logic [CA_W-1:0]   target_c;
	logic [CA_W-1:0]   diff_c;
	logic [CA_W-1:0]   delta_c;
	logic [CA_W-1:0]   ca_next_c;

	assign cw         = UCODE[pc_q];
	assign item_ready = cw.take_in;
	assign out_free   = !out_valid_q || result_ready;

	// branch condition of the current control word
	always_comb begin
		unique case (cw.cond)
			C_ALWAYS:   cond_true = 1'b1;
			C_IN_VALID: cond_true = item_valid;
			C_FLAT:     cond_true = flat_c;
			C_DIV_BUSY: cond_true = (cnt_q != '0);
			C_OUT_FREE: cond_true = out_free;
			default:    cond_true = 1'b1;
		endcase
	end

	// per-source levels; a tie goes to the led
	assign lt_c        = THR_W'(item_q.led_temp);
	assign mt_c        = THR_W'(item_q.mcu_temp);
	assign nl_c        = level_of(lt_c, LED_THR, led_level_q);
	assign nm_c        = level_of(mt_c, MCU_THR, mcu_level_q);
	assign mcu_rules_c = (nm_c > nl_c);

	// segment end points of the governing level; the top level is flat and never reads th
	assign nxt_idx_c = (lvl_q == LVL_W'(LEVELS - 1)) ? lvl_q : lvl_q + 1'b1;
	assign tl_c      = src_q ? MCU_THR[lvl_q] : LED_THR[lvl_q];
	assign th_c      = src_q ? MCU_THR[nxt_idx_c] : LED_THR[nxt_idx_c];
	assign cur_c     = GAIN_W'(INTENSITY[lvl_q]) << INTENSITY_SHIFT;
	assign nxt_c     = GAIN_W'(INTENSITY[lvl_q + 1'b1]) << INTENSITY_SHIFT;
	assign flat_c    = (INTENSITY[lvl_q] == INTENSITY[lvl_q + 1'b1]);
	assign ge_c      = (tsel_q >= tl_c);
	assign dist_c    = ge_c ? (tsel_q - tl_c) : (tl_c - tsel_q);
	assign span_c    = th_c - tl_c;

	// one restoring divide step
	assign r2_c   = {rem_q, quo_q[PROD_W-1]};
	assign qbit_c = (r2_c >= {1'b0, span_q});
	assign rsub_c = r2_c - {1'b0, span_q};

	// target with clamps at zero and at full intensity
	assign cur_w_c = PROD_W'(cur_q);
	assign up_c    = {1'b0, cur_w_c} + {1'b0, quo_q};
	always_comb begin
		priority if (flat_q) begin
			target_c = CA_W'(cur_q);
		end else if (ge_q) begin
			target_c = (cur_w_c >= quo_q) ? CA_W'(cur_w_c - quo_q) : '0;
		end else begin
			target_c = (up_c >= (PROD_W+1)'(TOP)) ? TOP : up_c[CA_W-1:0];
		end
	end

	// slew by a fraction of the gap, snap when that fraction is zero
	assign diff_c  = (ca_q > target_q) ? (ca_q - target_q) : (target_q - ca_q);
	assign delta_c = diff_c >> SLEW_SH;
	always_comb begin
		priority if (delta_c == '0) begin
			ca_next_c = target_q;
		end else if (ca_q < target_q) begin
			ca_next_c = ca_q + delta_c;
		end else begin
			ca_next_c = ca_q - delta_c;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= ST_IDLE;
			led_level_q <= '0;
			mcu_level_q <= '0;
			ca_q        <= CA_RESET;
			out_valid_q <= 1'b0;
		end else begin
			pc_q <= cond_true ? cw.jt : cw.jf;
			if (cw.op == OP_LEVEL) begin
				led_level_q <= nl_c;
				mcu_level_q <= nm_c;
			end
			if (cw.op == OP_SLEW) begin
				ca_q <= ca_next_c;
			end
			if (cw.op == OP_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath payload
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_q <= item;
		end
		unique case (cw.op)
			OP_NONE: begin
			end
			OP_LEVEL: begin
				src_q  <= mcu_rules_c;
				lvl_q  <= mcu_rules_c ? nm_c : nl_c;
				tsel_q <= mcu_rules_c ? mt_c : lt_c;
				err_q  <= (lt_c >= LED_THR[1]) || (mt_c >= MCU_THR[1]);
			end
			OP_SEG: begin
				flat_q <= flat_c;
				ge_q   <= ge_c;
				cur_q  <= cur_c;
				gain_q <= cur_c - nxt_c;
				dist_q <= dist_c[DIST_W-1:0];
				span_q <= span_c[SPAN_W-1:0];
			end
			OP_MUL: begin
				quo_q <= PROD_W'(gain_q * dist_q);
				rem_q <= '0;
				cnt_q <= '1;
			end
			OP_DIV: begin
				quo_q <= {quo_q[PROD_W-2:0], qbit_c};
				rem_q <= qbit_c ? rsub_c[SPAN_W-1:0] : r2_c[SPAN_W-1:0];
				cnt_q <= cnt_q - 1'b1;
			end
			OP_TARGET: begin
				target_q <= target_c;
			end
			OP_SLEW: begin
			end
			OP_EMIT: begin
				if (out_free) begin
					out_q.temp_adjust   <= ca_q[ADJ_W-1:0];
					out_q.protect_level <= lvl_q;
					out_q.derate_source <= src_q;
					out_q.temp_error    <= err_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

`ifndef SYNTHESIS
	// an accepted transfer always starts the level step next
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> (pc_q == ST_LEVEL))
		else $error("sequencer did not start after an input transfer");

	// a new result only comes from the emit step
	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> ($past(pc_q) == ST_EMIT))
		else $error("result appeared outside the emit step");

	// flat segments never enter the divider
	a_flat: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == ST_DIV) |-> !flat_q)
		else $error("divider running on a flat segment");

	// slewed value never exceeds the larger of reset value and full intensity
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		ca_q <= CA_MAX)
		else $error("slewed output out of range");

	// reported level is a real level
	a_level: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.protect_level <= LVL_W'(LEVELS - 1)))
		else $error("reported level out of range");
`endif

endmodule

// ===== tb/thermal_derating_intensity_test.sv =====
// self-checking testbench for the thermal derating intensity block
`timescale 1ns / 100ps

module thermal_derating_intensity_test;

	import tdi_pkg::*;

	// block configuration, shared by the instance and the predictor
	localparam int SCALE = 10;
	localparam int SHIFT = 6;

	// threshold bases in whole degrees and the intensity table in percent
	localparam int LED_DEG [7] = '{-40, 110, 114, 118, 122, 125, 129};
	localparam int MCU_DEG [7] = '{-40, 114, 118, 122, 126, 130, 135};
	localparam int PCT     [8] = '{100, 100, 90, 80, 70, 60, 0, 0};

	// one pending sample pair; hold_back makes the driver wait for an empty pipeline first
	typedef struct {
		item_t temps;
		bit    hold_back;
	} sample_t;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    item_valid   = 1'b0;
	logic    item_ready;
	item_t   item         = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;

	sample_t samples_todo[$];
	result_t expected_results[$];

	// predictor state: per-source levels and the slewed output
	logic [2:0]  led_lvl    = 3'd0;
	logic [2:0]  mcu_lvl    = 3'd0;
	logic [15:0] adjust_acc = 16'd6400;

	int fails       = 0;
	int n_sent      = 0;
	int n_checked   = 0;
	int n_mcu_gov   = 0;
	int n_overtemp  = 0;
	logic [6:0] levels_seen = '0;

	// idle counters of the two sides
	int send_gap = 0;
	int tx_quiet = 0;
	int rx_wait  = 0;
	int rx_quiet = 0;

	thermal_derating_intensity #(
		.TEMP_SCALE      (SCALE),
		.INTENSITY_SHIFT (SHIFT)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// threshold k of either source, in degrees times scale
	function automatic int thr_of(input bit is_mcu, input int k);
		return (is_mcu ? MCU_DEG[k] : LED_DEG[k]) * SCALE;
	endfunction

	// new derating level of one source, old level held outside every band
	function automatic logic [2:0] next_level(input int t, input bit is_mcu,
			input logic [2:0] old);
		int  hi;
		bit  hot5;
		if (t <= thr_of(is_mcu, 0))
			return old;
		if (t >= thr_of(is_mcu, 6))
			return 3'd6;
		// above the level 5 threshold the upper guard widens to two scale units
		hot5 = t >= thr_of(is_mcu, 5);
		for (int k = 0; k < 6; k++) begin
			hi = thr_of(is_mcu, k + 1) - (hot5 ? 2 * SCALE : SCALE);
			if (t >= thr_of(is_mcu, k) + SCALE && t < hi)
				return 3'(k);
		end
		return old;
	endfunction

	// interpolated intensity target for the governing source
	function automatic logic [15:0] seg_target(input int t, input bit is_mcu,
			input logic [2:0] lvl);
		int seg, tl, th;
		longint unsigned upper, lower, top, span, spread, corr, sum;
		seg   = (lvl > 3'd6) ? 6 : int'(lvl);
		upper = longint'(PCT[seg]) << SHIFT;
		lower = longint'(PCT[seg + 1]) << SHIFT;
		top   = longint'(100) << SHIFT;
		// flat segment: the table value itself, no division
		if (PCT[seg] == PCT[seg + 1])
			return upper[15:0];
		tl = thr_of(is_mcu, seg);
		th = thr_of(is_mcu, seg + 1);
		if (th <= tl) begin
			corr = 0;
		end else begin
			span   = longint'(th - tl);
			spread = (t >= tl) ? longint'(t - tl) : longint'(tl - t);
			corr   = (((upper - lower) * spread) / span) & 64'hFFFF_FFFF;
		end
		// below the segment start the correction pushes up, clamped to full scale
		if (t >= tl)
			return (upper >= corr) ? 16'(upper - corr) : 16'd0;
		sum = upper + corr;
		return (sum >= top) ? top[15:0] : sum[15:0];
	endfunction

	// advance the predictor by one sample pair and return the expected result
	function automatic result_t derate_step(input item_t it);
		int          lt, mt;
		bit          mcu_gov;
		logic [2:0]  lvl;
		logic [15:0] tgt, acc, slew;
		result_t     r;
		lt      = int'($signed(it.led_temp));
		mt      = int'($signed(it.mcu_temp));
		led_lvl = next_level(lt, 1'b0, led_lvl);
		mcu_lvl = next_level(mt, 1'b1, mcu_lvl);
		// a tie goes to the led
		mcu_gov = led_lvl < mcu_lvl;
		lvl     = mcu_gov ? mcu_lvl : led_lvl;
		tgt     = seg_target(mcu_gov ? mt : lt, mcu_gov, lvl);
		acc     = adjust_acc;
		slew    = 16'd0;
		if (acc < tgt) begin
			slew = (tgt - acc) >> (SHIFT + 1);
			acc  = acc + slew;
		end else if (acc > tgt) begin
			slew = (acc - tgt) >> (SHIFT + 1);
			acc  = acc - slew;
		end
		// step too small to move: snap onto the target
		if (slew == 16'd0)
			acc = tgt;
		adjust_acc      = acc;
		r.temp_adjust   = acc[ADJ_W-1:0];
		r.protect_level = lvl;
		r.derate_source = mcu_gov;
		r.temp_error    = (lt >= thr_of(1'b0, 1)) || (mt >= thr_of(1'b1, 1));
		return r;
	endfunction

	// idle length: mostly none or short, a few long, now and then a run with no idling
	function automatic int pick_gap(inout int quiet);
		int r;
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		r = $urandom_range(0, 199);
		if (r < 3) begin
			quiet = $urandom_range(20, 80);
			return 0;
		end
		if (r < 100)
			return 0;
		if (r < 170)
			return $urandom_range(1, 3);
		if (r < 194)
			return $urandom_range(4, 16);
		return $urandom_range(30, 120);
	endfunction

	// next temperature of a random walk that mostly stays around the threshold region
	function automatic int next_temp(input int prev, input int base);
		int r, v;
		r = $urandom_range(0, 99);
		if (r < 65 && prev > -1000 && prev < 2000)
			v = prev + int'($urandom_range(0, 50)) - 25;
		else if (r < 85)
			v = base - 150 + int'($urandom_range(0, 400));
		else if (r < 93)
			v = -700 + int'($urandom_range(0, 1000));
		else
			v = int'($signed(16'($urandom())));
		return v;
	endfunction

	task automatic queue_pair(input int led, input int mcu, input bit hold_back);
		sample_t s;
		s.temps.led_temp = 16'(led);
		s.temps.mcu_temp = 16'(mcu);
		s.hold_back      = hold_back;
		samples_todo.push_back(s);
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s expected %0d got %0d", name, want, got);
			fails++;
		end
	endtask

	// driver: offers queued pairs, predicts each one at its transfer
	always @(posedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && item_ready) begin
				expected_results.push_back(derate_step(item));
				n_sent++;
			end
			if (item_valid && !item_ready) begin
				// offer stays up with the same payload until taken
			end else if (send_gap > 0) begin
				send_gap--;
				item_valid <= 1'b0;
			end else if (samples_todo.size() == 0 ||
					(samples_todo[0].hold_back && expected_results.size() != 0)) begin
				item_valid <= 1'b0;
			end else begin
				item       <= samples_todo[0].temps;
				item_valid <= 1'b1;
				samples_todo.pop_front();
				send_gap = pick_gap(tx_quiet);
			end
		end
	end

	// monitor: compares each result transfer with the oldest prediction
	always @(posedge clk) begin
		result_t due;
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					$error("result transfer with no prediction waiting");
					fails++;
				end else begin
					due = expected_results.pop_front();
					check_field("temp_adjust", 16'(due.temp_adjust), 16'(result.temp_adjust));
					check_field("protect_level", 16'(due.protect_level),
						16'(result.protect_level));
					check_field("derate_source", 16'(due.derate_source),
						16'(result.derate_source));
					check_field("temp_error", 16'(due.temp_error), 16'(result.temp_error));
					n_checked++;
					if (due.derate_source)
						n_mcu_gov++;
					if (due.temp_error)
						n_overtemp++;
					levels_seen[due.protect_level] = 1'b1;
				end
				rx_wait = pick_gap(rx_quiet);
				// long back-pressure so the block fills and stalls its input
				if (n_checked == 120 || n_checked == 400)
					rx_wait = 400;
			end else if (rx_wait > 0) begin
				rx_wait--;
			end
			result_ready <= (rx_wait == 0);
		end
	end

	// stimulus and end of run
	initial begin
		int led_t, mcu_t;
		// nominal, both cold extremes, both hot extremes, then back to nominal
		queue_pair(0, 0, 1'b0);
		queue_pair(-32768, -32768, 1'b0);
		queue_pair(32767, 32767, 1'b0);
		queue_pair(0, 0, 1'b0);
		// led walks up the sloped levels
		queue_pair(1115, 0, 1'b0);
		queue_pair(1155, 0, 1'b0);
		queue_pair(1195, 1195, 1'b0);
		// equal levels, the led wins the tie
		queue_pair(1195, 1235, 1'b0);
		// mcu governs, then both reach level 4 and then level 5, and the led wins each tie
		queue_pair(0, 1280, 1'b0);
		queue_pair(1235, 1280, 1'b0);
		queue_pair(1265, 1315, 1'b0);
		// held level far below its segment clamps to full scale; wait for an empty pipe
		queue_pair(-32768, -32768, 1'b1);
		queue_pair(1275, -400, 1'b0);
		queue_pair(-399, -390, 1'b0);
		queue_pair(-390, 1139, 1'b0);
		// over-temperature flag edges of each source
		queue_pair(1099, 1140, 1'b0);
		queue_pair(1100, 0, 1'b0);
		// exact top threshold and a held top level
		queue_pair(1290, 0, 1'b0);
		queue_pair(1289, 1350, 1'b0);
		queue_pair(1115, 1155, 1'b0);
		// held low level far above its segment
		queue_pair(1275, 0, 1'b0);
		queue_pair(0, 0, 1'b0);
		queue_pair(32767, -32768, 1'b0);
		queue_pair(-32768, 32767, 1'b0);
		queue_pair(0, 0, 1'b0);

		// random walks around the thresholds with some full-range noise
		led_t = 0;
		mcu_t = 0;
		for (int i = 0; i < 530; i++) begin
			led_t = next_temp(led_t, 1100);
			mcu_t = next_temp(mcu_t, 1140);
			queue_pair(led_t, mcu_t, (i == 0) || ($urandom_range(0, 119) == 0));
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (samples_todo.size() != 0 || item_valid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		// let any stray result show up
		repeat (80) @(posedge clk);

		$display("%0d temperature pairs sent, %0d results checked, %0d flagged hot",
			n_sent, n_checked, n_overtemp);
		$display("levels reached (bit per level) %b, mcu governed %0d results",
			levels_seen, n_mcu_gov);
		if (fails == 0 && expected_results.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#5000000;
		$display("simulation failed");
		$finish;
	end

endmodule
